// ===== design/wsfd_pkg.sv =====
package wsfd_pkg;

    localparam int LEN_W = 63;

    // parse phases; codes 5..7 never occur and behave as PH_B1
    typedef enum logic [2:0] {
        PH_B1   = 3'd0,
        PH_B2   = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    localparam logic [6:0] LEN16_CODE  = 7'h7E;
    localparam logic [6:0] LEN64_CODE  = 7'h7F;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ORPHAN    = 2'd1;
    localparam logic [1:0] ST_BAD_OP    = 2'd2;

    localparam logic KIND_HDR = 1'b0;
    localparam logic KIND_PAY = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [7:0]       payload_byte;
        logic [3:0]       frame_opcode;
        logic             final_flag;
        logic [2:0]       reserved_bits;
        logic             was_masked;
        logic [LEN_W-1:0] payload_len;
        logic [1:0]       status;
        logic             last_of_frame;
    } t_out_item;

    // handshake between parser and result buffer
    typedef struct packed {
        logic push;
    } t_buf_ctl;

endpackage

// ===== design/wsfd_in_if.sv =====
interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== design/wsfd_out_if.sv =====
interface wsfd_out_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [7:0]                payload_byte;
    logic [3:0]                frame_opcode;
    logic                      final_flag;
    logic [2:0]                reserved_bits;
    logic                      was_masked;
    logic [wsfd_pkg::LEN_W-1:0] payload_len;
    logic [1:0]                status;
    logic                      last_of_frame;

    modport source (output valid, output kind, output payload_byte, output frame_opcode,
                    output final_flag, output reserved_bits, output was_masked,
                    output payload_len, output status, output last_of_frame,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_opcode,
                    input final_flag, input reserved_bits, input was_masked,
                    input payload_len, input status, input last_of_frame,
                    output ready);
endinterface

// ===== design/wsfd_parser.sv =====
module wsfd_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    output logic                 o_ready,
    input  logic                 i_space,
    output wsfd_pkg::t_buf_ctl   o_ctl,
    output wsfd_pkg::t_out_item  o_item
);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;

    wsfd_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                 r_b1, n_b1;
    logic [7:0]                 r_b2, n_b2;
    logic [wsfd_pkg::LEN_W-1:0] r_acc, n_acc;
    logic [3:0]                 r_left, n_left;
    logic [31:0]                r_key, n_key;
    logic [1:0]                 r_kidx, n_kidx;
    logic [wsfd_pkg::LEN_W-1:0] r_rem, n_rem;
    logic                       r_msg, n_msg;
    logic [1:0]                 r_status, n_status;

    logic                       w_adv;
    logic                       w_done;
    logic                       w_hdr;
    logic                       w_pay;
    logic [6:0]                 w_len7;
    logic [7:0]                 w_b2_upd;
    logic [wsfd_pkg::LEN_W-1:0] w_acc_upd;
    logic                       w_acc_zero;
    logic [7:0]                 w_key_byte;

    assign w_adv   = r_in_valid && i_space;
    assign o_ready = !r_in_valid || w_adv;
    assign w_len7  = r_in_byte[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    // header fields and length as they stand after this byte
    always_comb begin
        w_b2_upd  = (r_phase == wsfd_pkg::PH_B2) ? r_in_byte : r_b2;
        w_acc_upd = r_acc;
        case (r_phase)
            wsfd_pkg::PH_B2: begin
                if (w_len7 == wsfd_pkg::LEN16_CODE || w_len7 == wsfd_pkg::LEN64_CODE) begin
                    w_acc_upd = '0;
                end else begin
                    w_acc_upd = {{(wsfd_pkg::LEN_W-7){1'b0}}, w_len7};
                end
            end
            wsfd_pkg::PH_EXT: w_acc_upd = {r_acc[wsfd_pkg::LEN_W-9:0], r_in_byte};
            default:          w_acc_upd = r_acc;
        endcase
        w_acc_zero = (w_acc_upd == '0);
    end

    // next phase and step flags
    always_comb begin
        n_phase = r_phase;
        w_done  = 1'b0;
        w_hdr   = 1'b0;
        w_pay   = 1'b0;
        if (w_adv) begin
            case (r_phase)
                wsfd_pkg::PH_B2: begin
                    if (w_len7 == wsfd_pkg::LEN16_CODE || w_len7 == wsfd_pkg::LEN64_CODE) begin
                        n_phase = wsfd_pkg::PH_EXT;
                    end else begin
                        w_done = 1'b1;
                    end
                end
                wsfd_pkg::PH_EXT: begin
                    w_done = (r_left == 4'd1);
                end
                wsfd_pkg::PH_KEY: begin
                    w_hdr = (r_kidx == 2'd3);
                end
                wsfd_pkg::PH_DATA: begin
                    w_pay = 1'b1;
                    if (r_rem == {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1}) begin
                        n_phase = wsfd_pkg::PH_B1;
                    end
                end
                default: n_phase = wsfd_pkg::PH_B2;
            endcase
            if (w_done) begin
                if (w_b2_upd[7]) begin
                    n_phase = wsfd_pkg::PH_KEY;
                end else begin
                    w_hdr = 1'b1;
                end
            end
            if (w_hdr) begin
                n_phase = w_acc_zero ? wsfd_pkg::PH_B1 : wsfd_pkg::PH_DATA;
            end
        end
    end

    // datapath registers and result
    always_comb begin
        n_b1     = r_b1;
        n_b2     = r_b2;
        n_acc    = r_acc;
        n_left   = r_left;
        n_key    = r_key;
        n_kidx   = r_kidx;
        n_rem    = r_rem;
        n_msg    = r_msg;
        n_status = r_status;
        if (w_adv) begin
            n_acc = w_acc_upd;
            n_b2  = w_b2_upd;
            case (r_phase)
                wsfd_pkg::PH_B2: begin
                    if (w_len7 == wsfd_pkg::LEN16_CODE) begin
                        n_left = wsfd_pkg::EXT16_BYTES;
                    end else if (w_len7 == wsfd_pkg::LEN64_CODE) begin
                        n_left = wsfd_pkg::EXT64_BYTES;
                    end
                end
                wsfd_pkg::PH_EXT:  n_left = r_left - 4'd1;
                wsfd_pkg::PH_KEY: begin
                    n_key  = {r_key[23:0], r_in_byte};
                    n_kidx = r_kidx + 2'd1;
                end
                wsfd_pkg::PH_DATA: begin
                    n_kidx = r_kidx + 2'd1;
                    n_rem  = r_rem - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
                end
                default: n_b1 = r_in_byte;
            endcase
            if (w_done && w_b2_upd[7]) begin
                n_key  = '0;
                n_kidx = '0;
            end
            if (w_hdr) begin
                n_rem  = w_acc_upd;
                n_kidx = '0;
                if (r_b1[3:0] == wsfd_pkg::OP_CONT && !r_msg) begin
                    n_status = wsfd_pkg::ST_ORPHAN;
                    n_msg    = 1'b0;
                end else if (r_b1[3:0] <= wsfd_pkg::OP_BIN) begin
                    n_status = wsfd_pkg::ST_OK;
                    n_msg    = !r_b1[7];
                end else if (r_b1[3:0] == wsfd_pkg::OP_CLOSE ||
                             r_b1[3:0] == wsfd_pkg::OP_PING) begin
                    n_status = wsfd_pkg::ST_OK;
                end else begin
                    n_status = wsfd_pkg::ST_BAD_OP;
                    n_msg    = 1'b0;
                end
            end
        end
    end

    always_comb begin
        case (r_kidx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
        if (!r_b2[7]) begin
            w_key_byte = 8'h00;
        end
    end

    always_comb begin
        o_item.kind          = w_pay ? wsfd_pkg::KIND_PAY : wsfd_pkg::KIND_HDR;
        o_item.payload_byte  = w_pay ? (r_in_byte ^ w_key_byte) : 8'h00;
        o_item.frame_opcode  = r_b1[3:0];
        o_item.final_flag    = r_b1[7];
        o_item.reserved_bits = r_b1[6:4];
        o_item.was_masked    = w_b2_upd[7];
        o_item.payload_len   = w_acc_upd;
        o_item.status        = n_status;
        o_item.last_of_frame = w_pay ? (r_rem == {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1})
                                     : w_acc_zero;
        o_ctl.push           = w_hdr || w_pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsfd_pkg::PH_B1;
            r_b1     <= '0;
            r_b2     <= '0;
            r_acc    <= '0;
            r_left   <= '0;
            r_key    <= '0;
            r_kidx   <= '0;
            r_rem    <= '0;
            r_msg    <= 1'b0;
            r_status <= wsfd_pkg::ST_OK;
        end else begin
            r_phase  <= n_phase;
            r_b1     <= n_b1;
            r_b2     <= n_b2;
            r_acc    <= n_acc;
            r_left   <= n_left;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
            r_rem    <= n_rem;
            r_msg    <= n_msg;
            r_status <= n_status;
        end
    end

endmodule

// ===== design/wsfd_out_buf.sv =====
module wsfd_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wsfd_pkg::t_buf_ctl   i_ctl,
    input  wsfd_pkg::t_out_item  i_item,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output wsfd_pkg::t_out_item  o_item
);

    // two-entry result buffer: head drives the port, tail is the skid slot
    logic [1:0]          r_cnt, n_cnt;
    wsfd_pkg::t_out_item r_head, r_tail;
    logic                w_pop;
    logic                w_push;

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_head;
    assign w_pop   = o_valid && i_ready;
    assign w_push  = i_ctl.push;
    assign o_space = (r_cnt != 2'd2) || w_pop;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (w_push && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_head <= i_item;
            end else begin
                r_head <= r_tail;
                r_tail <= i_item;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_head <= i_item;
            end else begin
                r_tail <= i_item;
            end
        end else if (w_pop) begin
            r_head <= r_tail;
        end
    end

endmodule

// ===== design/websocket_frame_deframer_unit.sv =====
// channel  dir  modport  payload
// i_in     in   sink     stream_byte[7:0]
// o_out    out  source   kind, payload_byte, frame_opcode, final_flag, reserved_bits,
//                        was_masked, payload_len[62:0], status, last_of_frame
//
// One byte per clock sustained while the result buffer has space; a result passes the input register
// and is then decoded into the result buffer, which offers it.
// Header bytes, extended length and key give no item until the byte ending the header.
// Synchronous active-low reset returns to awaiting the first header byte, no message open.
// A two-entry result buffer lets the input keep running through an output stall until both
// entries are held; longer stalls back-pressure the input after two held items.
module websocket_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfd_in_if.sink     i_in,
    wsfd_out_if.source  o_out
);

    wsfd_pkg::t_buf_ctl  w_ctl;
    wsfd_pkg::t_out_item w_item;
    wsfd_pkg::t_out_item w_out;
    logic                w_space;

    wsfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.stream_byte),
        .o_ready (i_in.ready),
        .i_space (w_space),
        .o_ctl   (w_ctl),
        .o_item  (w_item)
    );

    wsfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_item  (w_item),
        .o_space (w_space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (w_out)
    );

    assign o_out.kind          = w_out.kind;
    assign o_out.payload_byte  = w_out.payload_byte;
    assign o_out.frame_opcode  = w_out.frame_opcode;
    assign o_out.final_flag    = w_out.final_flag;
    assign o_out.reserved_bits = w_out.reserved_bits;
    assign o_out.was_masked    = w_out.was_masked;
    assign o_out.payload_len   = w_out.payload_len;
    assign o_out.status        = w_out.status;
    assign o_out.last_of_frame = w_out.last_of_frame;

endmodule

// ===== design/wsfd_checker.sv =====
module wsfd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_kind,
    input logic [7:0]                 i_payload_byte,
    input logic [wsfd_pkg::LEN_W-1:0] i_payload_len,
    input logic                       i_last
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

    a_hdr_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == wsfd_pkg::KIND_HDR |-> i_payload_byte == 8'h00)
        else $error("header item carries a payload byte");

    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == wsfd_pkg::KIND_HDR |-> i_last == (i_payload_len == '0))
        else $error("header last flag disagrees with length");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_kind         (o_out.kind),
    .i_payload_byte (o_out.payload_byte),
    .i_payload_len  (o_out.payload_len),
    .i_last         (o_out.last_of_frame)
);

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsfd_pkg::*;

    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_PONG = 4'hA;
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_BYTES = 1100;
    localparam int CALM_AFTER = 950;
    localparam int PAUSE_AT = 550;
    localparam int LONG_HOLD = 80;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        t_out_item  res;
    } t_row;

    logic clk;
    logic rst_n;

    wsfd_in_if  in_if();
    wsfd_out_if out_if();

    websocket_frame_deframer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // deframer state as tracked on the bench side
    t_phase      ph = PH_B1;
    logic [7:0]  hdr_b1 = '0;
    logic [7:0]  hdr_b2 = '0;
    logic [62:0] len_acc = '0;
    logic [3:0]  ext_left = '0;
    logic [31:0] key_word = '0;
    logic [1:0]  key_idx = '0;
    logic [62:0] pay_left = '0;
    logic        msg_open = 1'b0;
    logic [1:0]  frame_st = ST_OK;

    t_out_item   frame_results_q[$];
    t_row        script_q[$];

    bit          row_typed = 1'b0;
    t_out_item   row_res = '0;
    bit          made;
    t_out_item   pred;

    bit          calm = 1'b0;
    bit          idling = 1'b1;
    bit          hold_out = 1'b0;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    int          fails = 0;
    int          n_checked = 0;
    int          n_headers = 0;
    int          n_orphan = 0;
    int          n_bad_op = 0;

    function automatic t_out_item frame_result(logic kind, logic [7:0] b, logic last);
        t_out_item r;
        r.kind          = kind;
        r.payload_byte  = b;
        r.frame_opcode  = hdr_b1[3:0];
        r.final_flag    = hdr_b1[7];
        r.reserved_bits = hdr_b1[6:4];
        r.was_masked    = hdr_b2[7];
        r.payload_len   = len_acc;
        r.status        = frame_st;
        r.last_of_frame = last;
        return r;
    endfunction

    task automatic close_header(output bit got, output t_out_item r);
        logic [3:0] op;
        logic       last;
        op = hdr_b1[3:0];
        if (op == OP_CONT && !msg_open) begin
            frame_st = ST_ORPHAN;
            msg_open = 1'b0;
        end else if (op <= OP_BIN) begin
            frame_st = ST_OK;
            msg_open = !hdr_b1[7];
        end else if (op == OP_CLOSE || op == OP_PING) begin
            frame_st = ST_OK;
        end else begin
            frame_st = ST_BAD_OP;
            msg_open = 1'b0;
        end
        pay_left = len_acc;
        key_idx  = '0;
        last     = (len_acc == '0);
        ph       = last ? PH_B1 : PH_DATA;
        n_headers++;
        if (frame_st == ST_ORPHAN) n_orphan++;
        if (frame_st == ST_BAD_OP) n_bad_op++;
        got = 1'b1;
        r   = frame_result(KIND_HDR, 8'h00, last);
    endtask

    // length known: either the key follows or the header is complete
    task automatic length_known(output bit got, output t_out_item r);
        if (hdr_b2[7]) begin
            key_word = '0;
            key_idx  = '0;
            ph       = PH_KEY;
            got      = 1'b0;
        end else begin
            close_header(got, r);
        end
    endtask

    task automatic parse_stream_byte(input logic [7:0] b, output bit got, output t_out_item r);
        logic [7:0] k;
        logic       last;
        got = 1'b0;
        r   = '0;
        case (ph)
            PH_B2: begin
                hdr_b2  = b;
                len_acc = '0;
                if (b[6:0] == LEN16_CODE) begin
                    ext_left = EXT16_BYTES;
                    ph       = PH_EXT;
                end else if (b[6:0] == LEN64_CODE) begin
                    ext_left = EXT64_BYTES;
                    ph       = PH_EXT;
                end else begin
                    len_acc = 63'(b[6:0]);
                    length_known(got, r);
                end
            end
            PH_EXT: begin
                len_acc  = {len_acc[54:0], b};
                ext_left = ext_left - 4'd1;
                if (ext_left == '0) length_known(got, r);
            end
            PH_KEY: begin
                key_word = {key_word[23:0], b};
                key_idx  = key_idx + 2'd1;
                if (key_idx == '0) close_header(got, r);
            end
            PH_DATA: begin
                k        = hdr_b2[7] ? key_word[8*(3-key_idx) +: 8] : 8'h00;
                key_idx  = key_idx + 2'd1;
                pay_left = pay_left - 63'd1;
                last     = (pay_left == '0);
                if (last) ph = PH_B1;
                got = 1'b1;
                r   = frame_result(KIND_PAY, b ^ k, last);
            end
            default: begin
                hdr_b1 = b;
                ph     = PH_B2;
            end
        endcase
    endtask

    function automatic string show(t_out_item r);
        return $sformatf("kind=%0d byte=%h op=%h fin=%b rsv=%0d masked=%b len=%0d st=%0d last=%b",
                         r.kind, r.payload_byte, r.frame_opcode, r.final_flag,
                         r.reserved_bits, r.was_masked, r.payload_len, r.status,
                         r.last_of_frame);
    endfunction

    task automatic check_result();
        t_out_item got;
        t_out_item want;
        bit        bad;
        got.kind          = out_if.kind;
        got.payload_byte  = out_if.payload_byte;
        got.frame_opcode  = out_if.frame_opcode;
        got.final_flag    = out_if.final_flag;
        got.reserved_bits = out_if.reserved_bits;
        got.was_masked    = out_if.was_masked;
        got.payload_len   = out_if.payload_len;
        got.status        = out_if.status;
        got.last_of_frame = out_if.last_of_frame;
        if (frame_results_q.size() == 0) begin
            fails++;
            if (fails <= 10) $display("%0t: unexpected result %s", $realtime, show(got));
            return;
        end
        want = frame_results_q.pop_front();
        n_checked++;
        bad = (got.kind !== want.kind) || (got.payload_byte !== want.payload_byte)
            || (got.frame_opcode !== want.frame_opcode) || (got.final_flag !== want.final_flag)
            || (got.reserved_bits !== want.reserved_bits)
            || (got.was_masked !== want.was_masked)
            || (got.payload_len !== want.payload_len) || (got.status !== want.status)
            || (got.last_of_frame !== want.last_of_frame);
        if (bad) begin
            fails++;
            if (fails <= 10) begin
                $display("%0t: mismatch on result %0d", $realtime, n_checked);
                $display("    expected %s", show(want));
                $display("    actual   %s", show(got));
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // check before predicting: a byte's result never leaves in the cycle it is taken
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_if.valid && out_if.ready) check_result();
            if (in_if.valid && in_if.ready) begin
                parse_stream_byte(in_if.stream_byte, made, pred);
                if (made) frame_results_q.push_back(row_typed ? row_res : pred);
            end
            if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, frame_results_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin
        int gap;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_out) begin
                hold_out = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                out_if.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 19);
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] hdr1(logic fin, logic [2:0] rsv, logic [3:0] op);
        return {fin, rsv, op};
    endfunction

    function automatic logic [7:0] hdr2(logic masked, logic [6:0] len7);
        return {masked, len7};
    endfunction

    function automatic t_out_item hdr_res(logic [3:0] op, logic fin, logic [2:0] rsv,
                                          logic masked, logic [62:0] len,
                                          logic [1:0] st, logic last);
        t_out_item r;
        r = '{kind: KIND_HDR, payload_byte: 8'h00, frame_opcode: op, final_flag: fin,
              reserved_bits: rsv, was_masked: masked, payload_len: len, status: st,
              last_of_frame: last};
        return r;
    endfunction

    function automatic void add(logic [7:0] b, bit typed = 1'b0, t_out_item res = '0);
        t_row row;
        row.b     = b;
        row.typed = typed;
        row.res   = res;
        script_q.push_back(row);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_out_item res = '0);
        int gap;
        if (idling && !calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_if.valid       <= 1'b1;
        in_if.stream_byte <= b;
        row_typed         <= typed;
        row_res           <= res;
        do @(posedge clk); while (!in_if.ready);
        bytes_sent++;
        if (bytes_sent >= CALM_AFTER) calm = 1'b1;
    endtask

    task automatic send_frame();
        logic [7:0] frame_q[$];
        logic [3:0] op;
        logic       fin;
        logic       masked;
        logic [2:0] rsv;
        int         n;
        int         sel;
        fin    = 1'($urandom);
        masked = 1'($urandom);
        rsv    = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'b000;
        sel    = $urandom_range(0, 19);
        if (sel < 4) op = OP_CONT;
        else if (sel < 8) op = OP_TEXT;
        else if (sel < 12) op = OP_BIN;
        else if (sel < 14) op = OP_CLOSE;
        else if (sel < 16) op = OP_PING;
        else if (sel < 17) op = OP_PONG;
        else begin
            do op = 4'($urandom);
            while (op <= OP_BIN || op == OP_CLOSE || op == OP_PING || op == OP_PONG);
        end
        // noise: arbitrary first byte
        frame_q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) : hdr1(fin, rsv, op));
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
            frame_q.push_back(hdr2(masked, 7'(n)));
        end else if (sel < 9) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
            frame_q.push_back(hdr2(masked, LEN16_CODE));
            frame_q.push_back(8'(n >> 8));
            frame_q.push_back(8'(n));
        end else begin
            // top bit of a 64-bit length is ignored
            n = $urandom_range(0, 30);
            frame_q.push_back(hdr2(masked, LEN64_CODE));
            frame_q.push_back({1'($urandom), 7'h00});
            repeat (6) frame_q.push_back(8'h00);
            frame_q.push_back(8'(n));
        end
        if (masked) repeat (4) frame_q.push_back(8'($urandom));
        repeat (n) frame_q.push_back(8'($urandom));
        idling = ($urandom_range(0, 2) != 0);
        foreach (frame_q[i]) send_byte(frame_q[i]);
    endtask

    initial begin
        bit paused;
        paused            = 1'b0;
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.stream_byte = 8'h00;

        // continuation with no message open, straight after reset
        add(hdr1(1'b0, 3'b000, OP_CONT));
        add(hdr2(1'b1, 7'd0));
        repeat (3) add(8'hFF);
        add(8'hFF, 1'b1, hdr_res(OP_CONT, 1'b0, 3'b000, 1'b1, 63'd0, ST_ORPHAN, 1'b1));
        // pong with every rsv bit set and an empty 16-bit length
        add(hdr1(1'b0, 3'b111, OP_PONG));
        add(hdr2(1'b0, LEN16_CODE));
        add(8'h00);
        add(8'h00, 1'b1, hdr_res(OP_PONG, 1'b0, 3'b111, 1'b0, 63'd0, ST_BAD_OP, 1'b1));
        // binary opens a message; 64-bit length with its top bit dropped
        add(hdr1(1'b0, 3'b000, OP_BIN));
        add(hdr2(1'b0, LEN64_CODE));
        add(8'h80);
        repeat (6) add(8'h00);
        add(8'h01, 1'b1, hdr_res(OP_BIN, 1'b0, 3'b000, 1'b0, 63'd1, ST_OK, 1'b0));
        add(8'hFF);
        // ping in the middle of the message
        add(hdr1(1'b1, 3'b000, OP_PING));
        add(hdr2(1'b0, 7'd0));
        // final masked continuation closes it
        add(hdr1(1'b1, 3'b000, OP_CONT));
        add(hdr2(1'b1, 7'd2));
        add(8'hA5);
        add(8'h00);
        add(8'hFF);
        add(8'h3C);
        add(8'h00);
        add(8'hFF);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script_q[i]) send_byte(script_q[i].b, script_q[i].typed, script_q[i].res);

        hold_out = 1'b1;
        while (bytes_sent < RANDOM_BYTES) begin
            if (!paused && bytes_sent >= PAUSE_AT) begin
                paused = 1'b1;
                @(negedge clk);
                in_if.valid <= 1'b0;
                while (frame_results_q.size() != 0) @(posedge clk);
            end
            send_frame();
        end

        @(negedge clk);
        in_if.valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (frame_results_q.size() != 0) begin
            fails += frame_results_q.size();
            $display("%0d expected results never arrived", frame_results_q.size());
        end
        $display("run: %0d stream bytes, %0d frame headers", bytes_sent, n_headers);
        $display("run: %0d orphan continuations, %0d bad opcodes, %0d results checked, %0d failures",
                 n_orphan, n_bad_op, n_checked, fails);
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
